// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the edge accumulator.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with an explicit implication from a trigger to a consequence.
`define ASSERT_IMPLY(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/ufm_pkg.sv -----
// Shared types and constants for the union-find edge accumulator.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ufm_pkg;

    localparam int NODE_W        = 10;
    localparam int COST_W        = 32;
    localparam int SUM_W         = 42;
    localparam int CNT_W         = 11;
    localparam int NODE_SPAN     = 1 << NODE_W;
    localparam int MAX_NODES_DEF = 1024;
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(1024);

    typedef struct packed {
        logic              start_graph;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [COST_W-1:0] edge_cost;
    } t_edge_req;

    typedef struct packed {
        logic             accepted;
        logic [SUM_W-1:0] total_cost;
        logic             bad_node;
    } t_edge_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clr_step;
        logic clr_sum;
        logic begin_find;
        logic find_step;
        logic comp_step;
        logic next_side;
        logic link;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start;
        logic bad;
        logic clr_last;
        logic root_done;
        logic comp_done;
        logic side;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- src/ufm_datapath.sv -----
// Datapath: parent table memory, root walk and path compression registers,
// saturating cost sum, node count register and the result register. Uses ufm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufm_datapath
    import ufm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_edge_req        i_in_data,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    input  wire logic             i_out_ready,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    output t_edge_rsp             o_out_data
);

    // Node fields cannot address beyond NODE_SPAN, so deeper tables add nothing.
    localparam int TABLE_DEPTH = (MAX_NODES < NODE_SPAN) ? MAX_NODES : NODE_SPAN;
    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_LIM = CNT_W'(TABLE_DEPTH);
    localparam logic [AW-1:0]    LAST_IDX  = AW'(TABLE_DEPTH - 1);

    logic [AW-1:0] r_mem [TABLE_DEPTH];
    logic [AW-1:0] r_rd_data;

    logic [NODE_W-1:0] r_a, n_a;
    logic [NODE_W-1:0] r_b, n_b;
    logic [COST_W-1:0] r_cost, n_cost;
    logic              r_start, n_start;
    logic              r_side, n_side;
    logic [AW-1:0]     r_root, n_root;
    logic [AW-1:0]     r_cur, n_cur;
    logic [AW-1:0]     r_ra, n_ra;
    logic              r_acc, n_acc;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [AW-1:0]     r_clr_idx, n_clr_idx;
    logic [CNT_W-1:0]  r_node_count, n_node_count;
    logic              r_out_valid, n_out_valid;
    t_edge_rsp         r_out_data, n_out_data;

    logic [CNT_W-1:0] w_limit;
    logic             w_bad;
    logic [AW-1:0]    w_node_sel;
    logic             w_root_done;
    logic             w_comp_done;
    logic             w_clr_last;
    logic             w_merge;
    logic [SUM_W:0]   w_sum_add;
    logic [SUM_W-1:0] w_sum_sat;
    logic [AW-1:0]    w_rd_addr;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_wr_data;

    assign w_limit     = (r_node_count < DEPTH_LIM) ? r_node_count : DEPTH_LIM;
    assign w_bad       = ({1'b0, r_a} >= w_limit) || ({1'b0, r_b} >= w_limit);
    assign w_node_sel  = r_side ? r_b[AW-1:0] : r_a[AW-1:0];
    assign w_root_done = !(r_rd_data < r_root);
    assign w_comp_done = (r_cur == r_root);
    assign w_clr_last  = (r_clr_idx == LAST_IDX);
    assign w_merge     = (r_ra != r_root);
    assign w_sum_add   = {1'b0, r_sum} + (SUM_W + 1)'(r_cost);
    // The sum never exceeds its maximum, so a carry out means saturation.
    assign w_sum_sat   = w_sum_add[SUM_W] ? {SUM_W{1'b1}} : w_sum_add[SUM_W-1:0];

    always_comb begin
        if (i_cmd.begin_find) begin
            w_rd_addr = w_node_sel;
        end else if (i_cmd.find_step) begin
            // Once the root is known, restart at the first node to compress.
            w_rd_addr = w_root_done ? r_cur : r_rd_data;
        end else if (i_cmd.comp_step) begin
            w_rd_addr = r_rd_data;
        end else begin
            w_rd_addr = r_root;
        end
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_clr_idx;
        w_wr_data = r_clr_idx;
        if (i_cmd.clr_step) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.comp_step && !w_comp_done) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_cur;
            w_wr_data = r_root;
        end else if (i_cmd.link && w_merge) begin
            // The larger root goes under the smaller one.
            w_wr_en   = 1'b1;
            w_wr_addr = (r_ra < r_root) ? r_root : r_ra;
            w_wr_data = (r_ra < r_root) ? r_ra : r_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_a          = r_a;
        n_b          = r_b;
        n_cost       = r_cost;
        n_start      = r_start;
        n_side       = r_side;
        n_root       = r_root;
        n_cur        = r_cur;
        n_ra         = r_ra;
        n_acc        = r_acc;
        n_sum        = r_sum;
        n_clr_idx    = r_clr_idx;
        n_node_count = r_node_count;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        if (i_cfg_we) begin
            n_node_count = i_cfg_wdata;
        end
        if (i_cmd.capture) begin
            n_a     = i_in_data.node_a;
            n_b     = i_in_data.node_b;
            n_cost  = i_in_data.edge_cost;
            n_start = i_in_data.start_graph;
            n_side  = 1'b0;
            n_acc   = 1'b0;
        end
        if (i_cmd.clr_step) begin
            n_clr_idx = w_clr_last ? '0 : r_clr_idx + 1'b1;
            if (w_clr_last) begin
                n_start = 1'b0;
            end
        end
        if (i_cmd.clr_sum) begin
            n_sum = '0;
        end
        if (i_cmd.begin_find) begin
            n_root = w_node_sel;
            n_cur  = w_node_sel;
        end
        if (i_cmd.find_step && !w_root_done) begin
            n_root = r_rd_data;
        end
        if (i_cmd.comp_step && !w_comp_done) begin
            n_cur = r_rd_data;
        end
        if (i_cmd.next_side) begin
            n_ra   = r_root;
            n_side = 1'b1;
        end
        if (i_cmd.link && w_merge) begin
            n_acc = 1'b1;
            n_sum = w_sum_sat;
        end
        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.out_load) begin
            n_out_valid           = 1'b1;
            n_out_data.accepted   = r_acc;
            n_out_data.total_cost = r_sum;
            n_out_data.bad_node   = w_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= 1'b0;
            r_side       <= 1'b0;
            r_sum        <= '0;
            r_clr_idx    <= '0;
            r_node_count <= NODE_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_start      <= n_start;
            r_side       <= n_side;
            r_sum        <= n_sum;
            r_clr_idx    <= n_clr_idx;
            r_node_count <= n_node_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_cost     <= n_cost;
        r_root     <= n_root;
        r_cur      <= n_cur;
        r_ra       <= n_ra;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    assign o_sts.start     = r_start;
    assign o_sts.bad       = w_bad;
    assign o_sts.clr_last  = w_clr_last;
    assign o_sts.root_done = w_root_done;
    assign o_sts.comp_done = w_comp_done;
    assign o_sts.side      = r_side;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- src/ufm_ctrl.sv -----
// Controller state machine: table sweeps, the two root walks with compression,
// the link step and the hand-off to the result register. Uses ufm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufm_ctrl
    import ufm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_WIPE  = 4'd3;
    localparam logic [3:0] S_ISSUE = 4'd4;
    localparam logic [3:0] S_FIND  = 4'd5;
    localparam logic [3:0] S_COMP  = 4'd6;
    localparam logic [3:0] S_LINK  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.clr_sum  = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.start) begin
                    n_state = S_WIPE;
                end else if (i_sts.bad) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_WIPE: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.clr_sum  = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_CHECK;
                end
            end
            S_ISSUE: begin
                o_cmd.begin_find = 1'b1;
                n_state          = S_FIND;
            end
            S_FIND: begin
                o_cmd.find_step = 1'b1;
                if (i_sts.root_done) begin
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                o_cmd.comp_step = 1'b1;
                if (i_sts.comp_done) begin
                    if (i_sts.side) begin
                        n_state = S_LINK;
                    end else begin
                        o_cmd.next_side = 1'b1;
                        n_state         = S_ISSUE;
                    end
                end
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ----- src/union_find_mst_edge_accumulator.sv -----
// Flow: a request with a bad endpoint goes straight to the result; otherwise both
// parent chains are walked to their roots and compressed, one parent table read
// per cycle, and the roots are linked. A start request first sweeps the table.
// Throughput: one request at a time; the next is taken the cycle after a result is
// loaded, and a result is loaded only once the previous one has been taken.
// Reset: synchronous, active low; a sweep over every table entry rebuilds the table.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module union_find_mst_edge_accumulator
    import ufm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_edge_req        i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_edge_rsp             o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    logic       w_in_fire;
    logic       w_bad_acc;
    logic [2:0] w_tbl_wr;

    ufm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ufm_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign w_in_fire = i_in_valid && o_in_ready;
    assign w_bad_acc = o_out_data.accepted && o_out_data.bad_node;
    assign w_tbl_wr  = {w_cmd.clr_step, w_cmd.comp_step, w_cmd.link};

    // A request is processed in the states after S_IDLE, so ready must drop after one is taken.
    `ASSERT_CLK(a_busy_after_req, i_clk, i_rst_n, w_in_fire |=> !o_in_ready, "ready held high")
    // A rejected edge is never reported as merged.
    `ASSERT_IMPLY(a_bad_not_acc, i_clk, i_rst_n, o_out_valid, !w_bad_acc, "bad edge accepted")
    // Only one command that writes the parent table may be active at a time.
    `ASSERT_CLK(a_one_writer, i_clk, i_rst_n, $onehot0(w_tbl_wr), "conflicting table writes")

endmodule

`default_nettype wire

// ----- tb/union_find_mst_edge_accumulator_test.sv -----
// Self-checking testbench for the union-find MST edge accumulator.
// Depends on ufm_pkg and the block itself; predicts each result with its own disjoint-set copy.
`timescale 1ns / 1ps

module union_find_mst_edge_accumulator_test
    import ufm_pkg::*;
();

    localparam int HOLD_CYCLES  = 3000;
    localparam int SETTLE_WAIT  = 8;
    localparam int TAIL_WAIT    = 20;
    localparam logic [SUM_W-1:0] SUM_CAP = '1;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_edge_req        in_data   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             in_ready;
    logic             out_valid;
    t_edge_rsp        out_data;

    // Predictor state: parent table, running sum and the node count in force.
    logic [NODE_W-1:0] forest_parent [NODE_SPAN];
    logic [SUM_W-1:0]  forest_sum;
    logic [CNT_W-1:0]  node_limit;

    t_edge_rsp   expected_rsp [$];
    t_edge_rsp   rsp_want;
    int unsigned mismatches   = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    logic        rx_hold      = 1'b0;
    logic [COST_W-1:0] graph_cost;
    event        hold_go;

    union_find_mst_edge_accumulator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    initial begin
        #500_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void clear_forest();
        for (int i = 0; i < NODE_SPAN; i++) begin
            forest_parent[i] = NODE_W'(i);
        end
        forest_sum = '0;
    endfunction

    // Walks up to the root, then points every node on the path straight at it.
    function automatic int unsigned find_root(int unsigned node);
        int unsigned root;
        int unsigned cur;
        int unsigned nxt;
        root = node;
        while (forest_parent[root] < root) root = forest_parent[root];
        cur = node;
        while (cur != root) begin
            nxt = forest_parent[cur];
            forest_parent[cur] = NODE_W'(root);
            cur = nxt;
        end
        return root;
    endfunction

    function automatic t_edge_rsp merge_edge(t_edge_req req);
        int unsigned lim;
        int unsigned ra;
        int unsigned rb;
        t_edge_rsp rsp;
        lim = (node_limit > MAX_NODES_DEF) ? MAX_NODES_DEF : node_limit;
        rsp = '0;
        if (req.start_graph) clear_forest();
        if (req.node_a >= lim || req.node_b >= lim) begin
            rsp.bad_node = 1'b1;
        end else begin
            ra = find_root(req.node_a);
            rb = find_root(req.node_b);
            if (ra != rb) begin
                if (ra < rb) forest_parent[rb] = NODE_W'(ra);
                else forest_parent[ra] = NODE_W'(rb);
                rsp.accepted = 1'b1;
                if (SUM_W'(req.edge_cost) > SUM_CAP - forest_sum) forest_sum = SUM_CAP;
                else forest_sum = forest_sum + SUM_W'(req.edge_cost);
            end
        end
        rsp.total_cost = forest_sum;
        return rsp;
    endfunction

    function automatic t_edge_req edge_of(bit start, int unsigned a, int unsigned b,
                                          logic [COST_W-1:0] cost);
        t_edge_req e;
        e.start_graph = start;
        e.node_a      = a[NODE_W-1:0];
        e.node_b      = b[NODE_W-1:0];
        e.edge_cost   = cost;
        return e;
    endfunction

    // Mostly in-range endpoints with rising costs; a few requests are plain noise.
    function automatic t_edge_req make_edge(bit start);
        t_edge_req   e;
        int unsigned span;
        int unsigned step;
        span = (node_limit > NODE_SPAN) ? NODE_SPAN : node_limit;
        e.start_graph = start;
        if (span == 0 || $urandom_range(99) < 8) begin
            e.node_a    = NODE_W'($urandom);
            e.node_b    = NODE_W'($urandom);
            e.edge_cost = $urandom;
        end else begin
            e.node_a = NODE_W'($urandom_range(span - 1));
            e.node_b = NODE_W'($urandom_range(span - 1));
            step = $urandom_range(1000);
            if (32'hFFFF_FFFF - graph_cost >= step) graph_cost = graph_cost + step;
            e.edge_cost = graph_cost;
        end
        return e;
    endfunction

    function automatic logic [CNT_W-1:0] pick_node_count();
        case ($urandom_range(19))
            0:       return '0;
            1:       return CNT_W'(1);
            2:       return CNT_W'(1024);
            3:       return '1;
            4:       return CNT_W'($urandom_range(1025, 2047));
            5, 6:    return CNT_W'($urandom_range(1, 1023));
            default: return CNT_W'($urandom_range(2, 48));
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_edge(t_edge_req item);
        t_edge_rsp rsp_new;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        rsp_new = merge_edge(item);
        expected_rsp = {expected_rsp, rsp_new};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_node_count(logic [CNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        node_limit = value;
    endtask

    task automatic set_idling(int unsigned tx_pct, int unsigned rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    task automatic test_directed();
        send_edge(edge_of(1, 0, 1023, 32'h0));
        send_edge(edge_of(0, 1023, 0, 32'hFFFF_FFFF));
        send_edge(edge_of(0, 5, 5, 32'h7));
        send_edge(edge_of(0, 1, 2, 32'hFFFF_FFFF));
        send_edge(edge_of(0, 2, 1023, 32'h1));
        send_edge(edge_of(0, 512, 511, 32'h8000_0000));
        // Builds the chain 13 -> 12 -> 11 -> 10, then walks and flattens it.
        send_edge(edge_of(0, 13, 12, 32'h8000_0001));
        send_edge(edge_of(0, 12, 11, 32'h8000_0002));
        send_edge(edge_of(0, 11, 10, 32'h8000_0003));
        send_edge(edge_of(0, 13, 0, 32'h8000_0004));
        send_edge(edge_of(0, 13, 12, 32'h8000_0005));
    endtask

    task automatic test_node_limits();
        wait_drained();
        write_node_count('0);
        send_edge(edge_of(1, 0, 0, 32'h5));
        send_edge(edge_of(0, 1023, 1023, 32'h5));
        wait_drained();
        write_node_count(CNT_W'(1));
        send_edge(edge_of(0, 0, 0, 32'h3));
        send_edge(edge_of(0, 0, 1, 32'h3));
        send_edge(edge_of(0, 1023, 0, 32'h3));
        wait_drained();
        write_node_count(CNT_W'(2));
        send_edge(edge_of(0, 1, 0, 32'h9));
        send_edge(edge_of(0, 1, 2, 32'h9));
        send_edge(edge_of(1, 0, 1, 32'h9));
        wait_drained();
        write_node_count('1);
        send_edge(edge_of(0, 1023, 0, 32'hFFFF_FFFF));
        send_edge(edge_of(0, 0, 1023, 32'hFFFF_FFFF));
        wait_drained();
        write_node_count(CNT_W'(1024));
        send_edge(edge_of(0, 1023, 512, 32'hFFFF_FFFF));
    endtask

    task automatic test_random_graphs(int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0) begin
                wait_drained();
                write_node_count(pick_node_count());
            end
            len = $urandom_range(8, 60);
            graph_cost = $urandom >> $urandom_range(31);
            for (int i = 0; i < len; i++) begin
                send_edge(make_edge(i == 0 || $urandom_range(99) < 2));
            end
            sent += len;
        end
    endtask

    // The receiver stops for a long stretch while requests keep coming.
    task automatic test_backpressure();
        wait_drained();
        write_node_count(CNT_W'(64));
        set_idling(0, 0);
        graph_cost = '0;
        -> hold_go;
        for (int i = 0; i < 16; i++) send_edge(make_edge(i == 0));
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 12; i++) send_edge(make_edge(0));
        wait_drained();
        for (int i = 0; i < 12; i++) send_edge(make_edge(0));
    endtask

    // A large random tree with costs near the top of the range drives the
    // total into its upper bits.
    task automatic test_big_tree(int unsigned n_links);
        int unsigned perm [NODE_SPAN];
        int unsigned j;
        int unsigned tmp;
        wait_drained();
        write_node_count(CNT_W'(1024));
        for (int i = 0; i < NODE_SPAN; i++) perm[i] = i;
        for (int i = NODE_SPAN - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        graph_cost = 32'hFFF0_0000;
        for (int i = 1; i <= n_links; i++) begin
            graph_cost = graph_cost + $urandom_range(255);
            if (i > 2 && $urandom_range(9) == 0) begin
                send_edge(edge_of(0, perm[$urandom_range(i - 1)], perm[$urandom_range(i - 1)],
                                  graph_cost));
            end
            j = $urandom_range(i - 1);
            if ($urandom_range(1)) send_edge(edge_of(i == 1, perm[i], perm[j], graph_cost));
            else send_edge(edge_of(i == 1, perm[j], perm[i], graph_cost));
        end
    endtask

    always begin
        @(hold_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk) begin
        if (rx_hold) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: result with no request pending: %p", $time, out_data);
                mismatches++;
            end else begin
                rsp_want = expected_rsp.pop_front();
                if (out_data.accepted !== rsp_want.accepted) begin
                    $display("%0t: accepted expected %0b actual %0b", $time,
                             rsp_want.accepted, out_data.accepted);
                    mismatches++;
                end
                if (out_data.total_cost !== rsp_want.total_cost) begin
                    $display("%0t: total_cost expected %0h actual %0h", $time,
                             rsp_want.total_cost, out_data.total_cost);
                    mismatches++;
                end
                if (out_data.bad_node !== rsp_want.bad_node) begin
                    $display("%0t: bad_node expected %0b actual %0b", $time,
                             rsp_want.bad_node, out_data.bad_node);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        clear_forest();
        node_limit = NODE_COUNT_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_node_limits();
        set_idling(59, 0);
        test_random_graphs(300);
        set_idling(0, 59);
        test_random_graphs(300);
        set_idling(9, 9);
        test_random_graphs(300);
        set_idling(0, 0);
        test_random_graphs(200);
        test_backpressure();
        test_drain_pause();
        set_idling(9, 9);
        test_big_tree(600);

        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
